>>> rtl/arpc_pkg.sv
package arpc_pkg;

  localparam int unsigned CacheEntries = 64;
  localparam int unsigned RequestSlots = 16;
  localparam int unsigned PortCount = 16;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUEUE  = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  localparam logic [2:0] KIND_LOOKUP = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_QUEUE  = 3'd2;
  localparam logic [2:0] KIND_SEND   = 3'd3;
  localparam logic [2:0] KIND_GIVEUP = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RESEND  = 2'd1;
  localparam logic [1:0] CFG_TRIES   = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET = 8'd15;
  localparam logic [7:0] RESEND_RESET  = 8'd1;
  localparam logic [2:0] TRIES_RESET   = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic        found;
    logic        refused;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [3:0]  port;
    logic        last;
  } result_t;

  // one request slot, as stored
  typedef struct packed {
    logic [31:0] ip;
    logic [3:0]  port;
    logic [2:0]  tries;
    logic [7:0]  age;
    logic        was_sent;
  } pend_t;

  // one cache entry, as stored
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  age;
  } entry_t;

endpackage

>>> rtl/arp_cache_with_request_retry.sv
// ARP cache: an IP-to-MAC table held in one RAM and a pending request table in a second RAM.
// Lookup walks every cache entry, one per cycle. Insert walks both tables; queue walks the
// request slots. A tick walks both tables and pushes a send or give-up result for each due
// request slot, waiting while the output register is full.
// One item at a time; reset (synchronous, rst high) clears valid bits and loads defaults.
module arp_cache_with_request_retry #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CacheEntries,
  parameter int unsigned REQUEST_SLOTS = arpc_pkg::RequestSlots,
  parameter int unsigned PORT_COUNT    = arpc_pkg::PortCount
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_addr,
  input  logic [3:0]  out_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic        found,
  output logic        refused,
  output logic [31:0] res_ip,
  output logic [47:0] res_mac,
  output logic [3:0]  res_port,
  output logic        last
);

  localparam int unsigned CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned PW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CWALK = 3'd1; // walk cache entries
  localparam logic [2:0] S_PWALK = 3'd2; // walk request slots
  localparam logic [2:0] S_EMIT  = 3'd3; // push result of a request slot (tick)
  localparam logic [2:0] S_FIN   = 3'd4; // commit and push final result

  logic [7:0] entry_timeout, resend_interval;
  logic [2:0] max_tries;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_timeout   <= arpc_pkg::TIMEOUT_RESET;
      resend_interval <= arpc_pkg::RESEND_RESET;
      max_tries       <= arpc_pkg::TRIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arpc_pkg::CFG_TIMEOUT: entry_timeout   <= cfg_data;
        arpc_pkg::CFG_RESEND:  resend_interval <= cfg_data;
        arpc_pkg::CFG_TRIES:   max_tries       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // memories
  arpc_pkg::entry_t cmem [CACHE_ENTRIES];
  arpc_pkg::pend_t  pmem [REQUEST_SLOTS];
  arpc_pkg::entry_t crd;
  arpc_pkg::pend_t  prd;
  logic [CW-1:0] craddr, cwaddr;
  logic [PW-1:0] praddr, pwaddr;
  logic cwe, pwe;
  arpc_pkg::entry_t cwd;
  arpc_pkg::pend_t  pwd;

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwaddr] <= cwd;
    crd <= cmem[craddr];
  end
  always_ff @(posedge clk) begin
    if (pwe) pmem[pwaddr] <= pwd;
    prd <= pmem[praddr];
  end

  logic [CACHE_ENTRIES-1:0] cvalid;
  logic [REQUEST_SLOTS-1:0] pvalid;

  logic [2:0]  state;
  logic [1:0]  op;
  logic [31:0] ip;
  logic [47:0] mac;
  logic [3:0]  port;
  logic [CW:0] ccnt;   // read address issued
  logic [PW:0] pcnt;
  logic        rdv;    // read data valid for index cidx or pidx
  logic [CW-1:0] cidx;
  logic [PW-1:0] pidx;
  logic        hit;
  logic [47:0] hit_mac;
  logic        free_ok;
  logic [CW-1:0] free_idx;
  logic        pm;      // pending match
  logic [PW-1:0] pm_idx;
  logic [3:0]  pm_port;
  arpc_pkg::pend_t pm_rec; // matched slot as read, kept for the queue update
  logic        pfree_ok;
  logic [PW-1:0] pfree_idx;
  logic        pport_bad;
  arpc_pkg::result_t emit_r;

  logic              push, space;
  arpc_pkg::result_t push_data, od;

  arpc_out_reg u_out (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .space(space),
    .valid(out_valid), .ready(out_ready), .data(od)
  );
  assign kind = od.kind;
  assign found = od.found;
  assign refused = od.refused;
  assign res_ip = od.ip;
  assign res_mac = od.mac;
  assign res_port = od.port;
  assign last = od.last;

  assign in_ready = (state == S_IDLE);
  assign pport_bad = ({4'd0, port} >= 8'(PORT_COUNT)) && (PORT_COUNT < 16);

  // tick update of a cache entry read back
  logic [7:0] cage_inc;
  assign cage_inc = (crd.age == 8'hff) ? crd.age : crd.age + 8'd1;
  arpc_pkg::pend_t pupd;
  logic [7:0] page_inc;
  logic       pdue, pgive;
  assign page_inc = (prd.age == 8'hff) ? prd.age : prd.age + 8'd1;
  assign pdue = !(prd.was_sent && page_inc <= resend_interval);
  assign pgive = prd.tries >= max_tries;

  always_comb begin
    pupd = prd;
    pupd.age = page_inc;
    if (pdue && !pgive) begin
      pupd.tries = prd.tries + 3'd1;
      pupd.age = 8'd0;
      pupd.was_sent = 1'b1;
    end
  end

  always_comb begin
    craddr = ccnt[CW-1:0];
    praddr = pcnt[PW-1:0];
    cwe = 1'b0; cwaddr = cidx; cwd = crd;
    pwe = 1'b0; pwaddr = pidx; pwd = pupd;
    push = 1'b0;
    push_data = emit_r;
    if (state == S_CWALK && rdv && op == arpc_pkg::REQ_TICK && cvalid[cidx]) begin
      cwe = 1'b1;
      cwd = crd;
      cwd.age = cage_inc;
    end
    if (state == S_PWALK && rdv && op == arpc_pkg::REQ_TICK && pvalid[pidx]) begin
      pwe = 1'b1;
    end
    if (state == S_EMIT) push = space;
    if (state == S_FIN && space) begin
      push = 1'b1;
      push_data = '0;
      push_data.ip = ip;
      push_data.last = 1'b1;
      unique case (op)
        arpc_pkg::REQ_LOOKUP: begin
          push_data.kind = arpc_pkg::KIND_LOOKUP;
          push_data.found = hit;
          push_data.mac = hit ? hit_mac : 48'd0;
        end
        arpc_pkg::REQ_INSERT: begin
          push_data.kind = arpc_pkg::KIND_INSERT;
          push_data.found = pm;
          push_data.port = pm ? pm_port : 4'd0;
          push_data.refused = !free_ok;
          cwe = free_ok;
          cwaddr = free_idx;
          cwd.ip = ip; cwd.mac = mac; cwd.age = 8'd0;
        end
        arpc_pkg::REQ_QUEUE: begin
          push_data.kind = arpc_pkg::KIND_QUEUE;
          push_data.port = port;
          push_data.found = !pport_bad && pm;
          push_data.refused = pport_bad || (!pm && !pfree_ok);
          pwe = !pport_bad && (pm || pfree_ok);
          pwaddr = pm ? pm_idx : pfree_idx;
          pwd.ip = ip; pwd.port = port; pwd.tries = 3'd0;
          pwd.age = 8'd0; pwd.was_sent = 1'b0;
          if (pm) begin
            pwd = pm_rec;
            pwd.port = port;
          end
        end
        default: begin
          push_data.kind = arpc_pkg::KIND_DONE;
          push_data.ip = 32'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cvalid <= '0;
      pvalid <= '0;
      rdv <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= req_type; ip <= ip_addr; mac <= mac_addr; port <= out_port;
            hit <= 1'b0; free_ok <= 1'b0; pm <= 1'b0; pfree_ok <= 1'b0;
            ccnt <= '0; pcnt <= '0; rdv <= 1'b0;
            state <= (req_type == arpc_pkg::REQ_QUEUE) ? S_PWALK : S_CWALK;
          end
        end
        S_CWALK: begin
          if (rdv) begin
            if (cvalid[cidx]) begin
              if (op == arpc_pkg::REQ_TICK) begin
                if (cage_inc > entry_timeout) cvalid[cidx] <= 1'b0;
              end else if (crd.ip == ip) begin
                hit <= 1'b1;
                hit_mac <= crd.mac;
              end
            end else if (!free_ok) begin
              free_ok <= 1'b1;
              free_idx <= cidx;
            end
          end
          if (ccnt == (CW+1)'(CACHE_ENTRIES)) begin
            rdv <= 1'b0;
            state <= (op == arpc_pkg::REQ_LOOKUP) ? S_FIN : S_PWALK;
          end else begin
            rdv <= 1'b1;
            cidx <= ccnt[CW-1:0];
            ccnt <= ccnt + 1'b1;
          end
        end
        S_PWALK: begin
          if (rdv && pvalid[pidx]) begin
            if (op == arpc_pkg::REQ_TICK) begin
              if (pdue) begin
                emit_r <= {pgive ? arpc_pkg::KIND_GIVEUP : arpc_pkg::KIND_SEND, 1'b0, 1'b0,
                           prd.ip, 48'd0, prd.port, 1'b0};
                if (pgive) pvalid[pidx] <= 1'b0;
              end
            end else if (prd.ip == ip && !pm) begin
              pm <= 1'b1;
              pm_idx <= pidx;
              pm_port <= prd.port;
              pm_rec <= prd;
            end
          end else if (rdv && !pvalid[pidx] && !pfree_ok) begin
            pfree_ok <= 1'b1;
            pfree_idx <= pidx;
          end
          if (rdv && pvalid[pidx] && op == arpc_pkg::REQ_TICK && pdue) begin
            rdv <= 1'b0;
            state <= S_EMIT;
          end else if (pcnt == (PW+1)'(REQUEST_SLOTS)) begin
            rdv <= 1'b0;
            state <= S_FIN;
          end else begin
            rdv <= 1'b1;
            pidx <= pcnt[PW-1:0];
            pcnt <= pcnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (space) state <= S_PWALK;
        end
        default: begin
          if (space) begin
            state <= S_IDLE;
            if (op == arpc_pkg::REQ_INSERT) begin
              if (pm) pvalid[pm_idx] <= 1'b0;
              if (free_ok) cvalid[free_idx] <= 1'b1;
            end
            if (op == arpc_pkg::REQ_QUEUE && !pport_bad && !pm && pfree_ok)
              pvalid[pfree_idx] <= 1'b1;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in_ready)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst) push |-> (state == S_FIN || state == S_EMIT))
    else $error("result pushed outside emit states");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_FIN && space) |=> state == S_IDLE)
    else $error("final result did not end the item");

endmodule

>>> rtl/arpc_out_reg.sv
module arpc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arpc_pkg::result_t push_data,
  output logic              space,
  output logic              valid,
  input  logic              ready,
  output arpc_pkg::result_t data
);

  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> space)
    else $error("result pushed into a full output register");
  assert property (@(posedge clk) disable iff (rst) (valid && !ready) |=> valid)
    else $error("stalled result lost");
  assert property (@(posedge clk) disable iff (rst)
      (valid && !ready && !$past(rst)) |=> $stable(data))
    else $error("stalled result changed");

endmodule

>>> tb/sv/tb.sv
module tb;

  class arp_scoreboard;
    arpc_pkg::result_t predicted_results[$];
    int       errors;
    logic [7:0] timeout_ticks, resend_ticks;
    logic [2:0] try_limit;
    logic        cache_valid [arpc_pkg::CacheEntries];
    logic [31:0] cache_ip    [arpc_pkg::CacheEntries];
    logic [47:0] cache_mac   [arpc_pkg::CacheEntries];
    logic [7:0]  cache_age   [arpc_pkg::CacheEntries];
    logic        req_valid   [arpc_pkg::RequestSlots];
    logic [31:0] req_ip      [arpc_pkg::RequestSlots];
    logic [3:0]  req_port    [arpc_pkg::RequestSlots];
    logic [2:0]  req_tries   [arpc_pkg::RequestSlots];
    logic [7:0]  req_age     [arpc_pkg::RequestSlots];
    logic        req_sent    [arpc_pkg::RequestSlots];

    function new();
      errors = 0;
      timeout_ticks = arpc_pkg::TIMEOUT_RESET;
      resend_ticks = arpc_pkg::RESEND_RESET;
      try_limit = arpc_pkg::TRIES_RESET;
      foreach (cache_valid[i]) cache_valid[i] = 1'b0;
      foreach (req_valid[i]) req_valid[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        arpc_pkg::CFG_TIMEOUT: timeout_ticks = val;
        arpc_pkg::CFG_RESEND:  resend_ticks = val;
        arpc_pkg::CFG_TRIES:   try_limit = val[2:0];
        default: ;
      endcase
    endfunction

    function void push(logic [2:0] k, logic f, logic r, logic [31:0] ip, logic [47:0] mac,
                       logic [3:0] port, logic lst);
      arpc_pkg::result_t res;
      res.kind = k; res.found = f; res.refused = r; res.ip = ip;
      res.mac = mac; res.port = port; res.last = lst;
      predicted_results.push_back(res);
    endfunction

    function int find_request(logic [31:0] ip);
      for (int i = 0; i < arpc_pkg::RequestSlots; i++)
        if (req_valid[i] && req_ip[i] == ip) return i;
      return -1;
    endfunction

    // predict the results of one accepted item and advance the table state
    function void note_item(logic [1:0] t, logic [31:0] ip, logic [47:0] mac, logic [3:0] port);
      int hit, p;
      logic f, r;
      logic [3:0] pp;
      hit = -1;
      case (t)
        arpc_pkg::REQ_LOOKUP: begin
          for (int i = 0; i < arpc_pkg::CacheEntries; i++)
            if (cache_valid[i] && cache_ip[i] == ip) hit = i;
          if (hit >= 0)
            push(arpc_pkg::KIND_LOOKUP, 1'b1, 1'b0, ip, cache_mac[hit], 4'd0, 1'b1);
          else push(arpc_pkg::KIND_LOOKUP, 1'b0, 1'b0, ip, 48'd0, 4'd0, 1'b1);
        end
        arpc_pkg::REQ_INSERT: begin
          p = find_request(ip);
          f = 1'b0; pp = 4'd0; r = 1'b1;
          if (p >= 0) begin
            f = 1'b1; pp = req_port[p]; req_valid[p] = 1'b0;
          end
          for (int i = 0; i < arpc_pkg::CacheEntries; i++)
            if (!cache_valid[i]) begin
              cache_valid[i] = 1'b1; cache_ip[i] = ip; cache_mac[i] = mac;
              cache_age[i] = 8'd0; r = 1'b0;
              break;
            end
          push(arpc_pkg::KIND_INSERT, f, r, ip, 48'd0, pp, 1'b1);
        end
        arpc_pkg::REQ_QUEUE: begin
          p = find_request(ip);
          if (int'(port) >= arpc_pkg::PortCount)
            push(arpc_pkg::KIND_QUEUE, 1'b0, 1'b1, ip, 48'd0, port, 1'b1);
          else if (p >= 0) begin
            req_port[p] = port;
            push(arpc_pkg::KIND_QUEUE, 1'b1, 1'b0, ip, 48'd0, port, 1'b1);
          end else begin
            r = 1'b1;
            for (int i = 0; i < arpc_pkg::RequestSlots; i++)
              if (!req_valid[i]) begin
                req_valid[i] = 1'b1; req_ip[i] = ip; req_port[i] = port;
                req_tries[i] = 3'd0; req_age[i] = 8'd0; req_sent[i] = 1'b0; r = 1'b0;
                break;
              end
            push(arpc_pkg::KIND_QUEUE, 1'b0, r, ip, 48'd0, port, 1'b1);
          end
        end
        default: begin
          for (int i = 0; i < arpc_pkg::CacheEntries; i++)
            if (cache_valid[i]) begin
              if (cache_age[i] != 8'hff) cache_age[i]++;
              if (cache_age[i] > timeout_ticks) cache_valid[i] = 1'b0;
            end
          for (int i = 0; i < arpc_pkg::RequestSlots; i++)
            if (req_valid[i]) begin
              if (req_age[i] != 8'hff) req_age[i]++;
              if (!(req_sent[i] && req_age[i] <= resend_ticks)) begin
                if (req_tries[i] >= try_limit) begin
                  req_valid[i] = 1'b0;
                  push(arpc_pkg::KIND_GIVEUP, 1'b0, 1'b0, req_ip[i], 48'd0, req_port[i], 1'b0);
                end else begin
                  push(arpc_pkg::KIND_SEND, 1'b0, 1'b0, req_ip[i], 48'd0, req_port[i], 1'b0);
                  req_tries[i] = req_tries[i] + 3'd1;
                  req_age[i] = 8'd0;
                  req_sent[i] = 1'b1;
                end
              end
            end
          push(arpc_pkg::KIND_DONE, 1'b0, 1'b0, 32'd0, 48'd0, 4'd0, 1'b1);
        end
      endcase
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(arpc_pkg::result_t got);
      arpc_pkg::result_t e;
      if (predicted_results.size() == 0) begin
        $error("unexpected result: kind %0d ip %0h", got.kind, got.ip);
        errors++;
        return;
      end
      e = predicted_results.pop_front();
      cmp("kind", 64'(e.kind), 64'(got.kind));
      cmp("found", 64'(e.found), 64'(got.found));
      cmp("refused", 64'(e.refused), 64'(got.refused));
      cmp("res_ip", 64'(e.ip), 64'(got.ip));
      cmp("res_mac", 64'(e.mac), 64'(got.mac));
      cmp("res_port", 64'(e.port), 64'(got.port));
      cmp("last", 64'(e.last), 64'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = 2'd0;
  logic [31:0] ip_addr = 32'd0;
  logic [47:0] mac_addr = 48'd0;
  logic [3:0]  out_port = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic        found, refused, last;
  logic [31:0] res_ip;
  logic [47:0] res_mac;
  logic [3:0]  res_port;

  arp_scoreboard sb = new();
  logic   quiet = 1'b0;
  int     sink_stall = 0;
  logic [31:0] ip_pool [8];

  arp_cache_with_request_retry dut (.*);

  always #4 clk = ~clk;

  initial begin
    #(8 * 2000000);
    $display("tb: errors");
    $finish;
  end

  // receiver: random stall bursts, none in the quiet part
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_result({kind, found, refused, res_ip, res_mac, res_port, last});

  // call at a falling edge; returns at a falling edge
  task automatic send_item(logic [1:0] t, logic [31:0] ip, logic [47:0] mac, logic [3:0] port);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_type = t; ip_addr = ip; mac_addr = mac; out_port = port;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(t, ip, mac, port);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.predicted_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(logic [7:0] tmo, logic [7:0] rsd, logic [7:0] tries);
    drain();
    write_reg(arpc_pkg::CFG_TIMEOUT, tmo);
    write_reg(arpc_pkg::CFG_RESEND, rsd);
    write_reg(arpc_pkg::CFG_TRIES, tries);
  endtask

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 9) < 7) return ip_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (k == n / 2 && $urandom_range(0, 1) == 0) drain();
      if (r < 25) send_item(arpc_pkg::REQ_LOOKUP, pick_ip(), 48'd0, 4'($urandom));
      else if (r < 50)
        send_item(arpc_pkg::REQ_INSERT, pick_ip(), {16'($urandom), 32'($urandom)}, 4'd0);
      else if (r < 78)
        send_item(arpc_pkg::REQ_QUEUE, pick_ip(), 48'd0, 4'($urandom_range(0, 15)));
      else send_item(arpc_pkg::REQ_TICK, $urandom(), {16'($urandom), 32'($urandom)},
                     4'($urandom));
    end
  endtask

  initial begin
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hffff_ffff;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // defaults: miss, hit, duplicate, queue match, insert clearing a request
    send_item(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, 48'd0, 4'd0);
    send_item(arpc_pkg::REQ_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff, 4'd0);
    send_item(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, 48'd0, 4'd0);
    send_item(arpc_pkg::REQ_INSERT, 32'hffff_ffff, 48'h0000_0000_0001, 4'd0);
    send_item(arpc_pkg::REQ_LOOKUP, 32'hffff_ffff, 48'd0, 4'd0);
    send_item(arpc_pkg::REQ_INSERT, 32'h0, 48'h0, 4'd0);
    send_item(arpc_pkg::REQ_QUEUE, 32'h0a00_0001, 48'd0, 4'd15);
    send_item(arpc_pkg::REQ_QUEUE, 32'h0a00_0001, 48'd0, 4'd0);
    send_item(arpc_pkg::REQ_QUEUE, 32'h0a00_0002, 48'd0, 4'd7);
    send_item(arpc_pkg::REQ_TICK, 32'd0, 48'd0, 4'd0);
    send_item(arpc_pkg::REQ_TICK, 32'd0, 48'd0, 4'd0);
    send_item(arpc_pkg::REQ_INSERT, 32'h0a00_0001, 48'h1234_5678_9abc, 4'd0);
    repeat (8) send_item(arpc_pkg::REQ_TICK, 32'd0, 48'd0, 4'd0);

    // request table full, never resent, zero try limit gives up at once
    set_regs(8'd255, 8'd255, 8'd7);
    for (int i = 0; i < 17; i++)
      send_item(arpc_pkg::REQ_QUEUE, 32'hc0a8_0000 + i, 48'd0, 4'(i));
    repeat (3) send_item(arpc_pkg::REQ_TICK, 32'd0, 48'd0, 4'd0);
    set_regs(8'd255, 8'd255, 8'd0);
    send_item(arpc_pkg::REQ_TICK, 32'd0, 48'd0, 4'd0);

    // cache full with entries that never expire
    for (int i = 0; i < 66; i++)
      send_item(arpc_pkg::REQ_INSERT, (i < 8) ? ip_pool[i] : 32'($urandom),
                {16'($urandom), 32'($urandom)}, 4'd0);
    send_item(arpc_pkg::REQ_QUEUE, ip_pool[2], 48'd0, 4'd3);
    send_item(arpc_pkg::REQ_INSERT, ip_pool[2], 48'hffff_ffff_ffff, 4'd0);
    random_items(10);

    // fast expiry, then retry settings
    set_regs(8'd1, 8'd1, 8'd1);
    repeat (3) send_item(arpc_pkg::REQ_TICK, 32'd0, 48'd0, 4'd0);
    random_items(8);
    set_regs(8'd254, 8'd254, 8'd7);
    random_items(8);
    set_regs(8'd3, 8'd2, 8'd3);
    random_items(8);
    set_regs(8'd0, 8'd0, 8'd2);
    quiet = 1'b1;
    random_items(8);

    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
